// ----- rtl/core/trc_pkg.sv -----
package trc_pkg;

  // Largest data payload of one block, in bytes
  localparam int BLOCK_SIZE = 512;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] WELL_KNOWN_PORT = 16'd69;
  localparam logic [15:0] OP_DATA = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [9:0] HEADER_LEN = 10'd4;
  localparam logic [10:0] RETRY_MAX = 11'd2047;
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  typedef enum logic [2:0] {
    CMD_OPEN  = 3'd0,
    CMD_PKT   = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLOSE = 3'd4,
    CMD_NONE  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RRQ  = 2'd1,
    KIND_ACK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_WAITING   = 3'd0,
    ST_BLOCK     = 3'd1,
    ST_EOF       = 3'd2,
    ST_SRV_ERROR = 3'd3,
    ST_TIMEOUT   = 3'd4,
    ST_BAD_OP    = 3'd5,
    ST_DELIVERED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  // One classified event, as it travels from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic        short_pkt;
    logic        is_data;
    logic        is_error;
    logic [15:0] blk;
    logic [15:0] sport;
    logic [9:0]  pay;
    logic        last;
    logic [9:0]  want;
  } event_t;

endpackage

// ----- rtl/core/trc_front.sv -----
module trc_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_command,
  input  logic [15:0]          in_opcode,
  input  logic [15:0]          in_block_number,
  input  logic [15:0]          in_source_port,
  input  logic [9:0]           in_packet_length,
  input  logic [9:0]           in_consume_count,
  input  logic                 q_full,
  output logic                 push,
  output trc_pkg::event_t      push_event
);

  localparam logic [10:0] BlkSize = 11'(trc_pkg::BLOCK_SIZE);

  logic [9:0] body;
  logic [9:0] pay;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Payload length, cut to one block
  assign body = in_packet_length - trc_pkg::HEADER_LEN;
  assign pay  = ({1'b0, body} > BlkSize) ? BlkSize[9:0] : body;

  always_comb begin
    unique case (in_command) inside
      trc_pkg::CMD_OPEN, trc_pkg::CMD_PKT, trc_pkg::CMD_TICK, trc_pkg::CMD_READ,
      trc_pkg::CMD_CLOSE: push_event.cmd = trc_pkg::cmd_t'(in_command);
      default:            push_event.cmd = trc_pkg::CMD_NONE;
    endcase
    push_event.short_pkt = in_packet_length < trc_pkg::HEADER_LEN;
    push_event.is_data   = in_opcode == trc_pkg::OP_DATA;
    push_event.is_error  = in_opcode == trc_pkg::OP_ERROR;
    push_event.blk       = in_block_number;
    push_event.sport     = in_source_port;
    push_event.pay       = pay;
    push_event.last      = {1'b0, pay} < BlkSize;
    push_event.want      = in_consume_count;
  end

endmodule

// ----- rtl/core/trc_queue.sv -----
module trc_queue #(
  parameter int DEPTH = trc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  trc_pkg::event_t push_event,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output trc_pkg::event_t head_event
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  trc_pkg::event_t slots_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = count_r == DepthCnt;
  assign head_valid = count_r != '0;
  assign head_event = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_event;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DepthCnt)
    else $error("event queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full event queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("event queue pointers disagree with empty count");

endmodule

// ----- rtl/core/trc_back.sv -----
module trc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data,
  input  logic            head_valid,
  input  trc_pkg::event_t head_event,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_send_kind,
  output logic [15:0]     out_send_block,
  output logic [15:0]     out_dest_port,
  output logic [2:0]      out_status,
  output logic [9:0]      out_delivered_count,
  output logic [15:0]     out_error_number
);

  logic [7:0]  timeout_r;
  logic [10:0] limit;

  trc_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     exp_blk_r, exp_blk_nxt;
  logic            locked_r, locked_nxt;
  logic [15:0]     srv_port_r, srv_port_nxt;
  logic [10:0]     retry_r, retry_nxt;
  logic [9:0]      remain_r, remain_nxt;
  logic            eof_r, eof_nxt;
  logic [15:0]     last_blk_r, last_blk_nxt;
  trc_pkg::kind_t  pend_r, pend_nxt;

  trc_pkg::kind_t  kind_nxt;
  logic [15:0]     send_blk_nxt;
  logic [15:0]     dport_nxt;
  trc_pkg::status_t status_nxt;
  logic [9:0]      count_nxt;
  logic [15:0]     err_nxt;

  logic            out_valid_r;
  trc_pkg::kind_t  kind_r;
  logic [15:0]     send_blk_r;
  logic [15:0]     dport_r;
  trc_pkg::status_t status_r;
  logic [9:0]      count_r;
  logic [15:0]     err_r;

  logic [15:0] dest;
  logic [15:0] blk_inc;
  logic [10:0] retry_inc;
  logic        timed_out;
  logic        bad_pkt;
  logic [9:0]  take;

  assign cfg_ready = 1'b1;
  assign limit     = {1'b0, timeout_r, 2'b00} + {3'b000, timeout_r};
  assign pop       = head_valid && (!out_valid_r || out_ready);

  assign dest      = locked_r ? srv_port_r : trc_pkg::WELL_KNOWN_PORT;
  assign blk_inc   = exp_blk_r + 16'd1;
  assign retry_inc = (retry_r < trc_pkg::RETRY_MAX) ? retry_r + 11'd1 : retry_r;
  assign timed_out = retry_inc >= limit;
  assign bad_pkt   = head_event.short_pkt
                  || (head_event.is_data && head_event.blk != blk_inc)
                  || (locked_r && head_event.sport != srv_port_r);
  assign take      = (head_event.want < remain_r) ? head_event.want : remain_r;

  always_comb begin
    phase_nxt    = phase_r;
    exp_blk_nxt  = exp_blk_r;
    locked_nxt   = locked_r;
    srv_port_nxt = srv_port_r;
    retry_nxt    = retry_r;
    remain_nxt   = remain_r;
    eof_nxt      = eof_r;
    last_blk_nxt = last_blk_r;
    pend_nxt     = pend_r;
    kind_nxt     = trc_pkg::KIND_NONE;
    send_blk_nxt = '0;
    dport_nxt    = '0;
    status_nxt   = trc_pkg::ST_WAITING;
    count_nxt    = '0;
    err_nxt      = '0;

    unique case (head_event.cmd) inside
      trc_pkg::CMD_OPEN: begin
        phase_nxt    = trc_pkg::PH_WAIT;
        exp_blk_nxt  = '0;
        locked_nxt   = 1'b0;
        srv_port_nxt = trc_pkg::WELL_KNOWN_PORT;
        retry_nxt    = '0;
        remain_nxt   = '0;
        eof_nxt      = 1'b0;
        last_blk_nxt = '0;
        pend_nxt     = trc_pkg::KIND_RRQ;
        kind_nxt     = trc_pkg::KIND_RRQ;
        dport_nxt    = trc_pkg::WELL_KNOWN_PORT;
      end
      trc_pkg::CMD_PKT, trc_pkg::CMD_TICK: begin
        if (phase_r == trc_pkg::PH_WAIT) begin
          if (head_event.cmd == trc_pkg::CMD_TICK || bad_pkt) begin
            // Retry: resend the pending packet or give up
            retry_nxt = retry_inc;
            if (timed_out) begin
              status_nxt = trc_pkg::ST_TIMEOUT;
            end else begin
              kind_nxt     = pend_r;
              send_blk_nxt = (pend_r == trc_pkg::KIND_ACK) ? exp_blk_r : '0;
              dport_nxt    = dest;
            end
          end else begin
            if (!locked_r) begin
              locked_nxt   = 1'b1;
              srv_port_nxt = head_event.sport;
            end
            if (head_event.is_data) begin
              exp_blk_nxt = blk_inc;
              remain_nxt  = head_event.pay;
              retry_nxt   = '0;
              pend_nxt    = trc_pkg::KIND_NONE;
              phase_nxt   = trc_pkg::PH_READY;
              if (head_event.last) begin
                eof_nxt      = 1'b1;
                last_blk_nxt = blk_inc;
                status_nxt   = trc_pkg::ST_EOF;
              end else begin
                status_nxt = trc_pkg::ST_BLOCK;
              end
            end else if (head_event.is_error) begin
              status_nxt = trc_pkg::ST_SRV_ERROR;
              err_nxt    = head_event.blk;
            end else begin
              status_nxt = trc_pkg::ST_BAD_OP;
            end
          end
          // Session failure: drop back depending on what was pending
          if (status_nxt == trc_pkg::ST_TIMEOUT || status_nxt == trc_pkg::ST_SRV_ERROR
              || status_nxt == trc_pkg::ST_BAD_OP) begin
            if (pend_r == trc_pkg::KIND_RRQ) begin
              phase_nxt = trc_pkg::PH_IDLE;
              eof_nxt   = 1'b0;
            end else begin
              phase_nxt = trc_pkg::PH_READY;
            end
            remain_nxt = '0;
            pend_nxt   = trc_pkg::KIND_NONE;
            retry_nxt  = '0;
          end
        end
      end
      trc_pkg::CMD_READ: begin
        if (phase_r == trc_pkg::PH_IDLE) begin
          status_nxt = trc_pkg::ST_EOF;
        end else if (phase_r == trc_pkg::PH_READY) begin
          if (remain_r != '0) begin
            remain_nxt = remain_r - take;
            status_nxt = trc_pkg::ST_DELIVERED;
            count_nxt  = take;
          end else if (eof_r) begin
            status_nxt = trc_pkg::ST_EOF;
          end else begin
            phase_nxt    = trc_pkg::PH_WAIT;
            pend_nxt     = trc_pkg::KIND_ACK;
            retry_nxt    = '0;
            kind_nxt     = trc_pkg::KIND_ACK;
            send_blk_nxt = exp_blk_r;
            dport_nxt    = dest;
          end
        end
      end
      trc_pkg::CMD_CLOSE: begin
        if (eof_r) begin
          kind_nxt     = trc_pkg::KIND_ACK;
          send_blk_nxt = last_blk_r;
          dport_nxt    = dest;
        end
        phase_nxt    = trc_pkg::PH_IDLE;
        exp_blk_nxt  = '0;
        locked_nxt   = 1'b0;
        srv_port_nxt = trc_pkg::WELL_KNOWN_PORT;
        retry_nxt    = '0;
        remain_nxt   = '0;
        eof_nxt      = 1'b0;
        last_blk_nxt = '0;
        pend_nxt     = trc_pkg::KIND_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= trc_pkg::TIMEOUT_RESET;
      phase_r     <= trc_pkg::PH_IDLE;
      exp_blk_r   <= '0;
      locked_r    <= 1'b0;
      srv_port_r  <= trc_pkg::WELL_KNOWN_PORT;
      retry_r     <= '0;
      remain_r    <= '0;
      eof_r       <= 1'b0;
      last_blk_r  <= '0;
      pend_r      <= trc_pkg::KIND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
      if (pop) begin
        phase_r     <= phase_nxt;
        exp_blk_r   <= exp_blk_nxt;
        locked_r    <= locked_nxt;
        srv_port_r  <= srv_port_nxt;
        retry_r     <= retry_nxt;
        remain_r    <= remain_nxt;
        eof_r       <= eof_nxt;
        last_blk_r  <= last_blk_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on pop, hold otherwise
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r     <= kind_nxt;
      send_blk_r <= send_blk_nxt;
      dport_r    <= dport_nxt;
      status_r   <= status_nxt;
      count_r    <= count_nxt;
      err_r      <= err_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_send_kind       = kind_r;
  assign out_send_block      = send_blk_r;
  assign out_dest_port       = dport_r;
  assign out_status          = status_r;
  assign out_delivered_count = count_r;
  assign out_error_number    = err_r;

  a_wait_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == trc_pkg::PH_WAIT) == (pend_r != trc_pkg::KIND_NONE))
    else $error("pending packet and wait phase disagree");

  a_port_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    !locked_r |-> srv_port_r == trc_pkg::WELL_KNOWN_PORT)
    else $error("server port changed before lock");

  a_buffer_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (remain_r != '0) |-> phase_r == trc_pkg::PH_READY)
    else $error("buffered bytes outside ready phase");

  a_eof_not_wait: assert property (@(posedge clk) disable iff (!rst_n)
    eof_r |-> phase_r != trc_pkg::PH_WAIT)
    else $error("waiting for data after end of file");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped event left no result");

endmodule

// ----- rtl/core/tftp_read_client.sv -----
// Channel | Direction | Transfer when          | Payload
// in_     | input     | in_valid & in_ready    | command, opcode, block, port, length, count
// out_    | output    | out_valid & out_ready  | send kind/block, dest port, status, count, error
// cfg_    | input     | cfg_valid & cfg_ready  | timeout_seconds (8 bits)
//
// One event per cycle sustained while out_ready holds high; out_valid rises once the input
// transfer has passed the queue slot and then the output register.
// The sequencer is a compare-and-update on registered session state; cfg_ready is always high.
// Reset (rst_n low, synchronous) empties the queue, restores the session state and
// sets timeout_seconds to 5. A stalled output holds its result; the queue keeps
// taking events until it is full, then in_ready drops.
module tftp_read_client #(
  parameter int QUEUE_DEPTH = trc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_block_number,
  input  logic [15:0] in_source_port,
  input  logic [9:0]  in_packet_length,
  input  logic [9:0]  in_consume_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_send_kind,
  output logic [15:0] out_send_block,
  output logic [15:0] out_dest_port,
  output logic [2:0]  out_status,
  output logic [9:0]  out_delivered_count,
  output logic [15:0] out_error_number
);

  logic            q_full;
  logic            push;
  trc_pkg::event_t push_event;
  logic            pop;
  logic            head_valid;
  trc_pkg::event_t head_event;

  trc_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_opcode        (in_opcode),
    .in_block_number  (in_block_number),
    .in_source_port   (in_source_port),
    .in_packet_length (in_packet_length),
    .in_consume_count (in_consume_count),
    .q_full           (q_full),
    .push             (push),
    .push_event       (push_event)
  );

  trc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_event (push_event),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_event (head_event)
  );

  trc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .head_valid          (head_valid),
    .head_event          (head_event),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_send_kind       (out_send_kind),
    .out_send_block      (out_send_block),
    .out_dest_port       (out_dest_port),
    .out_status          (out_status),
    .out_delivered_count (out_delivered_count),
    .out_error_number    (out_error_number)
  );

endmodule
